// ===== rtl/rbs_pkg.sv =====
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared types and codes of the ray/box slab intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rbs_pkg;

   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CENTER_X = 3'd0,
      CSR_CENTER_Y = 3'd1,
      CSR_CENTER_Z = 3'd2,
      CSR_HALF_X   = 3'd3,
      CSR_HALF_Y   = 3'd4,
      CSR_HALF_Z   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic en;
      logic neg;
   } mul_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/ray_box_slab_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Ray against axis-aligned box, slab method, signed fixed point.
// ----------------------------------------------------------------------------
// One ray enters per cycle while req_tready is high (Q16.16 by default). Most
// of the latency is the reciprocal of each direction component, a restoring
// divider that resolves one quotient bit per pipeline stage; the two slab
// multiplies and the hit-point multiply take three stages each. A two-entry
// output buffer lets the pipeline keep taking rays after the result side
// stalls, until its second entry fills. The user must write the box through
// the csr port only while no ray is in flight; the block does not enforce it.
`default_nettype none

module ray_box_slab_intersect #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       csr_wr_en,
   input  wire logic [rbs_pkg::CSR_INDEX_W-1:0]            csr_index,
   input  wire logic [COORD_WIDTH-1:0]                     csr_wdata,
   input  wire logic                                       req_tvalid,
   output logic                                            req_tready,
   // ray_origin_x, ray_origin_y, ray_origin_z, ray_dir_x, ray_dir_y, ray_dir_z
   input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0]         req_tdata,
   output logic                                            rsp_tvalid,
   input  wire logic                                       rsp_tready,
   // hit_distance, hit_point_x, hit_point_y, hit_point_z
   output logic [((4*COORD_WIDTH-1+7)/8)*8-1:0]            rsp_tdata,
   // hit
   output logic                                            rsp_tuser
);

   localparam int CW    = COORD_WIDTH;
   localparam int FB    = FRAC_BITS;
   localparam int QW    = 2*FB + 1;
   localparam int QS    = (QW > CW) ? QW : CW;
   localparam int NW    = CW + 2;
   localparam int PW    = 2*NW + 2 + 2*CW;
   localparam int ML    = 3;
   localparam int RSP_W = ((4*CW-1+7)/8)*8;

   logic adv;

   // configuration
   logic signed [CW-1:0] ctr_ff  [3];
   logic [CW-2:0]        half_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            ctr_ff[i]  <= '0;
            half_ff[i] <= '0;
         end
      end else if (csr_wr_en) begin
         unique case (rbs_pkg::csr_index_type'(csr_index))
            rbs_pkg::CSR_CENTER_X: ctr_ff[0]  <= csr_wdata;
            rbs_pkg::CSR_CENTER_Y: ctr_ff[1]  <= csr_wdata;
            rbs_pkg::CSR_CENTER_Z: ctr_ff[2]  <= csr_wdata;
            rbs_pkg::CSR_HALF_X:   half_ff[0] <= csr_wdata[CW-2:0];
            rbs_pkg::CSR_HALF_Y:   half_ff[1] <= csr_wdata[CW-2:0];
            rbs_pkg::CSR_HALF_Z:   half_ff[2] <= csr_wdata[CW-2:0];
            default: ;
         endcase
      end
   end

   // stage A: slab numerators and direction magnitude
   logic          a_v_ff;
   logic [PW-1:0] a_pl_ff [3];
   logic [CW-1:0] a_m_ff  [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (adv) begin
         a_v_ff <= req_tvalid;
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_axis_a
      logic [CW-1:0] org, dir, ctr;
      logic [NW-1:0] org_x, ctr_x, half_x, na_in, nb_in;
      logic [CW-1:0] m_in;

      assign org    = req_tdata[i*CW +: CW];
      assign dir    = req_tdata[(3+i)*CW +: CW];
      assign ctr    = ctr_ff[i];
      assign org_x  = {{2{org[CW-1]}}, org};
      assign ctr_x  = {{2{ctr[CW-1]}}, ctr};
      assign half_x = {3'b000, half_ff[i]};
      assign na_in  = ctr_x - org_x - half_x;
      assign nb_in  = half_x - org_x + ctr_x;
      assign m_in   = dir[CW-1] ? (~dir + CW'(1)) : dir;

      always_ff @(posedge clock) begin
         if (adv) begin
            a_pl_ff[i] <= {na_in, nb_in, dir[CW-1], (dir == '0), org, dir};
            a_m_ff[i]  <= m_in;
         end
      end
   end

   // reciprocal
   logic          d_v  [3];
   logic [QW-1:0] d_q  [3];
   logic [PW-1:0] d_pl [3];

   for (genvar i = 0; i < 3; i++) begin : g_recip
      rbs_recip #(.CW(CW), .FB(FB), .PW(PW)) u_recip (
         .clock      (clock),
         .reset      (reset),
         .en         (adv),
         .in_valid   (a_v_ff),
         .in_mag     (a_m_ff[i]),
         .in_payload (a_pl_ff[i]),
         .out_valid  (d_v[i]),
         .out_quot   (d_q[i]),
         .out_payload(d_pl[i])
      );
   end

   // stage R: saturated reciprocal and numerator magnitudes
   logic          r_v_ff;
   logic [CW-2:0] r_inv_ff  [3];
   logic [CW:0]   r_na_ff   [3];
   logic [CW:0]   r_nb_ff   [3];
   logic          r_nan_ff  [3];
   logic          r_nbn_ff  [3];
   logic [CW-1:0] r_org_ff  [3];
   logic [CW-1:0] r_dir_ff  [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         r_v_ff <= 1'b0;
      end else if (adv) begin
         r_v_ff <= d_v[0];
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_axis_r
      logic [NW-1:0] na, nb, na_abs, nb_abs;
      logic          dneg, dzero;
      logic [CW-1:0] org, dir;
      logic [QS-1:0] q_ext;
      logic          q_sat;

      assign {na, nb, dneg, dzero, org, dir} = d_pl[i];
      assign q_ext  = QS'(d_q[i]);
      assign q_sat  = |q_ext[QS-1:CW-1];
      assign na_abs = na[NW-1] ? (NW'(0) - na) : na;
      assign nb_abs = nb[NW-1] ? (NW'(0) - nb) : nb;

      always_ff @(posedge clock) begin
         if (adv) begin
            r_inv_ff[i] <= (dzero || q_sat) ? {(CW-1){1'b1}} : q_ext[CW-2:0];
            r_na_ff[i]  <= na_abs[CW:0];
            r_nb_ff[i]  <= nb_abs[CW:0];
            r_nan_ff[i] <= na[NW-1] ^ dneg;
            r_nbn_ff[i] <= nb[NW-1] ^ dneg;
            r_org_ff[i] <= org;
            r_dir_ff[i] <= dir;
         end
      end
   end

   // slab multiplies
   logic signed [CW-1:0] ta [3];
   logic signed [CW-1:0] tb [3];
   logic                 sm_v_ff   [ML];
   logic [CW-1:0]        sm_org_ff [ML][3];
   logic [CW-1:0]        sm_dir_ff [ML][3];

   for (genvar i = 0; i < 3; i++) begin : g_slab
      rbs_qmul #(.AW(CW+1), .BW(CW-1), .FB(FB), .OW(CW-1)) u_mul_a (
         .clock(clock),
         .ctl  ('{en: adv, neg: r_nan_ff[i]}),
         .a_mag(r_na_ff[i]),
         .b_mag(r_inv_ff[i]),
         .res  (ta[i])
      );
      rbs_qmul #(.AW(CW+1), .BW(CW-1), .FB(FB), .OW(CW-1)) u_mul_b (
         .clock(clock),
         .ctl  ('{en: adv, neg: r_nbn_ff[i]}),
         .a_mag(r_nb_ff[i]),
         .b_mag(r_inv_ff[i]),
         .res  (tb[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < ML; s++) sm_v_ff[s] <= 1'b0;
      end else if (adv) begin
         sm_v_ff[0] <= r_v_ff;
         for (int s = 1; s < ML; s++) sm_v_ff[s] <= sm_v_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sm_org_ff[0][i] <= r_org_ff[i];
            sm_dir_ff[0][i] <= r_dir_ff[i];
            for (int s = 1; s < ML; s++) begin
               sm_org_ff[s][i] <= sm_org_ff[s-1][i];
               sm_dir_ff[s][i] <= sm_dir_ff[s-1][i];
            end
         end
      end
   end

   // stage C: order each slab
   logic                 c_v_ff;
   logic signed [CW-1:0] c_lo_ff  [3];
   logic signed [CW-1:0] c_hi_ff  [3];
   logic [CW-1:0]        c_org_ff [3];
   logic [CW-1:0]        c_dir_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (adv) begin
         c_v_ff <= sm_v_ff[ML-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            c_lo_ff[i]  <= (ta[i] < tb[i]) ? ta[i] : tb[i];
            c_hi_ff[i]  <= (ta[i] < tb[i]) ? tb[i] : ta[i];
            c_org_ff[i] <= sm_org_ff[ML-1][i];
            c_dir_ff[i] <= sm_dir_ff[ML-1][i];
         end
      end
   end

   // stage E: entry and exit
   logic                 e_v_ff;
   logic signed [CW-1:0] e_tmin_ff, e_tmax_ff;
   logic signed [CW-1:0] tmin01, tmax01;
   logic [CW-1:0]        e_org_ff [3];
   logic [CW-1:0]        e_dir_ff [3];

   assign tmin01 = (c_lo_ff[1] > c_lo_ff[0]) ? c_lo_ff[1] : c_lo_ff[0];
   assign tmax01 = (c_hi_ff[1] < c_hi_ff[0]) ? c_hi_ff[1] : c_hi_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (adv) begin
         e_v_ff <= c_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_tmin_ff <= (c_lo_ff[2] > tmin01) ? c_lo_ff[2] : tmin01;
         e_tmax_ff <= (c_hi_ff[2] < tmax01) ? c_hi_ff[2] : tmax01;
         e_org_ff  <= c_org_ff;
         e_dir_ff  <= c_dir_ff;
      end
   end

   // stage F: hit decision and distance
   logic          f_v_ff, f_hit_ff;
   logic [CW-2:0] f_dist_ff;
   logic [CW-1:0] f_dmag_ff [3];
   logic          f_dneg_ff [3];
   logic [CW-1:0] f_org_ff  [3];
   logic          hit_in;

   assign hit_in = !(e_tmax_ff < 0 || e_tmin_ff > e_tmax_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
      end else if (adv) begin
         f_v_ff <= e_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_hit_ff <= hit_in;
         if (!hit_in) begin
            f_dist_ff <= '0;
         end else if (e_tmin_ff < 0) begin
            f_dist_ff <= e_tmax_ff[CW-2:0];
         end else begin
            f_dist_ff <= e_tmin_ff[CW-2:0];
         end
         for (int i = 0; i < 3; i++) begin
            f_dmag_ff[i] <= e_dir_ff[i][CW-1] ? (~e_dir_ff[i] + CW'(1)) : e_dir_ff[i];
            f_dneg_ff[i] <= e_dir_ff[i][CW-1];
            f_org_ff[i]  <= e_org_ff[i];
         end
      end
   end

   // hit-point multiplies
   logic signed [CW:0] pm [3];
   logic               hm_v_ff    [ML];
   logic               hm_hit_ff  [ML];
   logic [CW-2:0]      hm_dist_ff [ML];
   logic [CW-1:0]      hm_org_ff  [ML][3];

   for (genvar i = 0; i < 3; i++) begin : g_point
      rbs_qmul #(.AW(CW), .BW(CW-1), .FB(FB), .OW(CW)) u_mul_p (
         .clock(clock),
         .ctl  ('{en: adv, neg: f_dneg_ff[i]}),
         .a_mag(f_dmag_ff[i]),
         .b_mag(f_dist_ff),
         .res  (pm[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < ML; s++) hm_v_ff[s] <= 1'b0;
      end else if (adv) begin
         hm_v_ff[0] <= f_v_ff;
         for (int s = 1; s < ML; s++) hm_v_ff[s] <= hm_v_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hm_hit_ff[0]  <= f_hit_ff;
         hm_dist_ff[0] <= f_dist_ff;
         hm_org_ff[0]  <= f_org_ff;
         for (int s = 1; s < ML; s++) begin
            hm_hit_ff[s]  <= hm_hit_ff[s-1];
            hm_dist_ff[s] <= hm_dist_ff[s-1];
            hm_org_ff[s]  <= hm_org_ff[s-1];
         end
      end
   end

   // stage G: add origin back, clamp, pack
   logic             g_v_ff, g_hit_ff;
   logic [RSP_W-1:0] g_data_ff;
   logic [CW-1:0]    pt [3];

   for (genvar i = 0; i < 3; i++) begin : g_axis_g
      logic [CW+1:0] sum;
      logic [CW-1:0] org;
      logic          ovf;

      assign org = hm_org_ff[ML-1][i];
      assign sum = {pm[i][CW], pm[i]} + {{2{org[CW-1]}}, org};
      assign ovf = (sum[CW+1] != sum[CW]) || (sum[CW] != sum[CW-1]);

      always_comb begin
         if (!hm_hit_ff[ML-1]) begin
            pt[i] = '0;
         end else if (ovf) begin
            pt[i] = sum[CW+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
         end else begin
            pt[i] = sum[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_v_ff <= 1'b0;
      end else if (adv) begin
         g_v_ff <= hm_v_ff[ML-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_hit_ff  <= hm_hit_ff[ML-1];
         g_data_ff <= RSP_W'({pt[2], pt[1], pt[0], hm_dist_ff[ML-1]});
      end
   end

   // output register with skid entry
   logic             out_v_ff, skid_v_ff;
   logic             out_hit_ff, skid_hit_ff;
   logic [RSP_W-1:0] out_data_ff, skid_data_ff;
   logic             take, push;

   assign adv  = !skid_v_ff;
   assign take = out_v_ff && rsp_tready;
   assign push = adv && g_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (take) begin
         if (skid_v_ff) begin
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= push;
         end
      end else if (push) begin
         if (out_v_ff) begin
            skid_v_ff <= 1'b1;
         end else begin
            out_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && skid_v_ff) begin
         out_hit_ff  <= skid_hit_ff;
         out_data_ff <= skid_data_ff;
      end else if (push && (take || !out_v_ff)) begin
         out_hit_ff  <= g_hit_ff;
         out_data_ff <= g_data_ff;
      end
      if (push && out_v_ff && !take) begin
         skid_hit_ff  <= g_hit_ff;
         skid_data_ff <= g_data_ff;
      end
   end

   assign req_tready = adv;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_hit_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry held without output entry");

   a_skid_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && !rsp_tready))
      else $error("skid entry filled while output was free");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("miss item carries nonzero data");

   a_recip_aligned: assert property (@(posedge clock) disable iff (reset)
      (d_v[0] == d_v[1]) && (d_v[1] == d_v[2]))
      else $error("reciprocal lanes out of step");

endmodule

`default_nettype wire

// ===== rtl/rbs_recip.sv =====
// ----------------------------------------------------------------------------
// rbs_recip
// Pipelined restoring divider: 2^(2*FB) / mag, one quotient bit per stage,
// with a payload carried beside each stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rbs_recip #(
   parameter int CW = 32,
   parameter int FB = 16,
   parameter int PW = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire logic [CW-1:0]       in_mag,
   input  wire logic [PW-1:0]       in_payload,
   output logic                     out_valid,
   output logic [2*FB:0]            out_quot,
   output logic [PW-1:0]            out_payload
);

   localparam int QW = 2*FB + 1;

   logic          v_ff   [QW];
   logic [CW-1:0] rem_ff [QW];
   logic [CW-1:0] m_ff   [QW];
   logic [QW-1:0] q_ff   [QW];
   logic [PW-1:0] pl_ff  [QW];

   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic          prev_v;
      logic [CW-1:0] prev_rem;
      logic [CW-1:0] prev_m;
      logic [QW-1:0] prev_q;
      logic [PW-1:0] prev_pl;
      logic [CW:0]   trial;
      logic          ge;
      logic [CW-1:0] rem_in;
      logic [QW-1:0] q_in;

      if (s == 0) begin : g_first
         assign prev_v   = in_valid;
         assign prev_rem = '0;
         assign prev_m   = in_mag;
         assign prev_q   = '0;
         assign prev_pl  = in_payload;
      end else begin : g_next
         assign prev_v   = v_ff[s-1];
         assign prev_rem = rem_ff[s-1];
         assign prev_m   = m_ff[s-1];
         assign prev_q   = q_ff[s-1];
         assign prev_pl  = pl_ff[s-1];
      end

      assign trial  = {prev_rem, ((s == 0) ? 1'b1 : 1'b0)};
      assign ge     = trial >= {1'b0, prev_m};
      assign rem_in = ge ? CW'(trial - {1'b0, prev_m}) : CW'(trial);
      assign q_in   = {prev_q[QW-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= prev_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in;
            m_ff[s]   <= prev_m;
            q_ff[s]   <= q_in;
            pl_ff[s]  <= prev_pl;
         end
      end
   end

   assign out_valid   = v_ff[QW-1];
   assign out_quot    = q_ff[QW-1];
   assign out_payload = pl_ff[QW-1];

endmodule

`default_nettype wire

// ===== rtl/rbs_qmul.sv =====
// ----------------------------------------------------------------------------
// rbs_qmul
// Three-stage fixed-point multiply of magnitudes: split partial products,
// sum with shift and saturation, then sign.
// ----------------------------------------------------------------------------
`default_nettype none

module rbs_qmul #(
   parameter int AW = 33,
   parameter int BW = 31,
   parameter int FB = 16,
   parameter int OW = 31
) (
   input  wire logic                clock,
   input  wire rbs_pkg::mul_ctl_type ctl,
   input  wire logic [AW-1:0]       a_mag,
   input  wire logic [BW-1:0]       b_mag,
   output logic signed [OW:0]       res
);

   localparam int BL = BW / 2;
   localparam int BH = BW - BL;
   localparam int FW = AW + BW;
   localparam int SW = (FW - FB > OW) ? FW - FB : OW + 1;

   logic [AW+BL-1:0] lo_in, lo_ff;
   logic [AW+BH-1:0] hi_in, hi_ff;
   logic             neg1_ff, neg2_ff;
   logic [FW-1:0]    full;
   logic [SW-1:0]    shifted;
   logic [OW-1:0]    mag_in, mag_ff;
   logic [OW:0]      res_in, res_ff;

   assign lo_in = (AW+BL)'(a_mag) * (AW+BL)'(b_mag[BL-1:0]);
   assign hi_in = (AW+BH)'(a_mag) * (AW+BH)'(b_mag[BW-1:BL]);

   assign full    = FW'(lo_ff) + (FW'(hi_ff) << BL);
   assign shifted = SW'(full >> FB);
   assign mag_in  = (|shifted[SW-1:OW]) ? {OW{1'b1}} : shifted[OW-1:0];

   assign res_in = neg2_ff ? ((OW+1)'(0) - {1'b0, mag_ff}) : {1'b0, mag_ff};

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         neg1_ff <= ctl.neg;
         mag_ff  <= mag_in;
         neg2_ff <= neg1_ff;
         res_ff  <= res_in;
      end
   end

   assign res = $signed(res_ff);

endmodule

`default_nettype wire

// ===== tb/tb_ray_box_slab_intersect.sv =====
// ----------------------------------------------------------------------------
// tb_ray_box_slab_intersect
// Streams rays against a series of box settings, predicts hit, distance and
// hit point of each ray in Q16.16, and checks every result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ray_box_slab_intersect;

   localparam int  CW      = 32;
   localparam int  FB      = 16;
   localparam longint SMAX = 64'sd2147483647;
   localparam longint SMIN = -64'sd2147483648;
   localparam longint UMAX = 64'sd4294967295;
   localparam int  LATENCY = 2*FB + 14;

   typedef struct {
      logic signed [31:0] org[3];
      logic signed [31:0] dir[3];
   } ray_type;

   typedef struct {
      bit        hit;
      bit [30:0] distance;
      bit [31:0] pt[3];
   } box_hit_type;

   class slab_scoreboard;
      longint      ctr[3];
      longint      half[3];
      box_hit_type hits_due[$];
      int          errors;

      function void write_reg(rbs_pkg::csr_index_type idx, logic [31:0] val);
         case (idx)
            rbs_pkg::CSR_CENTER_X: ctr[0] = longint'($signed(val));
            rbs_pkg::CSR_CENTER_Y: ctr[1] = longint'($signed(val));
            rbs_pkg::CSR_CENTER_Z: ctr[2] = longint'($signed(val));
            rbs_pkg::CSR_HALF_X:   half[0] = longint'(val[30:0]);
            rbs_pkg::CSR_HALF_Y:   half[1] = longint'(val[30:0]);
            rbs_pkg::CSR_HALF_Z:   half[2] = longint'(val[30:0]);
            default: ;
         endcase
      endfunction

      function longint fx_mul(longint a, longint b, longint lim);
         logic [127:0]    p;
         longint unsigned x, y;
         longint          r;
         x = (a < 0) ? -a : a;
         y = (b < 0) ? -b : b;
         p = {64'd0, x} * {64'd0, y};
         p = p >> FB;
         r = (p > lim) ? lim : longint'(p[63:0]);
         return (((a < 0) != (b < 0)) ? -r : r);
      endfunction

      function longint recip(longint d);
         longint q;
         if (d == 0) return SMAX;
         q = (64'sd1 <<< (2*FB)) / ((d < 0) ? -d : d);
         if (q > SMAX) q = SMAX;
         return (d < 0) ? -q : q;
      endfunction

      function void note_ray(ray_type r);
         box_hit_type e;
         longint      o, inv, ta, tb, lo, hi, tmin, tmax, p;
         tmin = 0;
         tmax = 0;
         for (int i = 0; i < 3; i++) begin
            o   = longint'(r.org[i]) - ctr[i];
            inv = recip(longint'(r.dir[i]));
            ta  = fx_mul(-(half[i] + o), inv, SMAX);
            tb  = fx_mul(half[i] - o, inv, SMAX);
            lo  = (ta < tb) ? ta : tb;
            hi  = (ta < tb) ? tb : ta;
            if (i == 0 || lo > tmin) tmin = lo;
            if (i == 0 || hi < tmax) tmax = hi;
         end
         e.hit = 0;
         e.distance = '0;
         for (int i = 0; i < 3; i++) e.pt[i] = '0;
         if (!(tmax < 0 || tmin > tmax)) begin
            if (tmin < 0) tmin = tmax;
            e.hit      = 1;
            e.distance = tmin[30:0];
            for (int i = 0; i < 3; i++) begin
               p = fx_mul(longint'(r.dir[i]), tmin, UMAX) + longint'(r.org[i]);
               if (p > SMAX) p = SMAX;
               if (p < SMIN) p = SMIN;
               e.pt[i] = p[31:0];
            end
         end
         hits_due.push_back(e);
      endfunction

      function void check_result(box_hit_type a);
         box_hit_type e;
         if (hits_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result hit=%0b d=%h", a.hit, a.distance);
            return;
         end
         e = hits_due.pop_front();
         if (a.hit !== e.hit || a.distance !== e.distance || a.pt[0] !== e.pt[0] ||
             a.pt[1] !== e.pt[1] || a.pt[2] !== e.pt[2]) begin
            errors++;
            if (errors <= 10)
               $display("mismatch exp hit=%0b d=%h p=%h %h %h | act hit=%0b d=%h p=%h %h %h",
                        e.hit, e.distance, e.pt[0], e.pt[1], e.pt[2],
                        a.hit, a.distance, a.pt[0], a.pt[1], a.pt[2]);
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         csr_wr_en = 0;
   logic [2:0]   csr_index = '0;
   logic [31:0]  csr_wdata = '0;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [191:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [127:0] rsp_tdata;
   logic         rsp_tuser;

   slab_scoreboard sb = new;
   int burst_left = 0;

   ray_box_slab_intersect dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #(20 * 400000);
      $display("ray_box_slab_intersect regression: fail");
      $finish;
   end

   task automatic write_reg(rbs_pkg::csr_index_type idx, logic [31:0] val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic set_box(longint cx, longint cy, longint cz,
                          longint hx, longint hy, longint hz);
      req_tvalid <= 0;
      while (sb.hits_due.size() > 0) @(posedge clock);
      write_reg(rbs_pkg::CSR_CENTER_X, cx[31:0]);
      write_reg(rbs_pkg::CSR_CENTER_Y, cy[31:0]);
      write_reg(rbs_pkg::CSR_CENTER_Z, cz[31:0]);
      write_reg(rbs_pkg::CSR_HALF_X, {1'b0, hx[30:0]});
      write_reg(rbs_pkg::CSR_HALF_Y, {1'b0, hy[30:0]});
      write_reg(rbs_pkg::CSR_HALF_Z, {1'b0, hz[30:0]});
      csr_wr_en <= 0;
   endtask

   task automatic send_ray(ray_type r);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 12);
         burst_left = $urandom_range(1, 24);
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_tvalid <= 1;
      req_tdata  <= {r.dir[2], r.dir[1], r.dir[0], r.org[2], r.org[1], r.org[0]};
      do @(posedge clock); while (!req_tready);
      sb.note_ray(r);
   endtask

   task automatic send_xyz(longint ox, longint oy, longint oz,
                           longint dx, longint dy, longint dz);
      ray_type r;
      r.org[0] = ox[31:0]; r.org[1] = oy[31:0]; r.org[2] = oz[31:0];
      r.dir[0] = dx[31:0]; r.dir[1] = dy[31:0]; r.dir[2] = dz[31:0];
      send_ray(r);
   endtask

   function automatic ray_type make_ray();
      ray_type r;
      int      kind;
      longint  o;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
         if (kind < 6) begin
            o = sb.ctr[i] + longint'($signed($urandom_range(0, 65536 * 8))) - 65536 * 4
                + (($urandom_range(0, 1) == 1) ? sb.half[i] : -sb.half[i])
                  * $urandom_range(0, 3);
            r.org[i] = o[31:0];
            o = sb.ctr[i] - o + longint'($urandom_range(0, 8192)) - 4096;
            if ($urandom_range(0, 7) == 0) o = 0;
            else if ($urandom_range(0, 3) == 0) o = o >>> $urandom_range(0, 8);
            r.dir[i] = o[31:0];
         end else if (kind < 8) begin
            r.org[i] = $urandom;
            r.dir[i] = $urandom;
         end else begin
            r.org[i] = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
            r.dir[i] = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
         end
      end
      return r;
   endfunction

   initial begin
      int mode, n;
      mode = 0;
      n = 0;
      forever begin
         @(posedge clock);
         n++;
         if (n >= 1500 && n < 1800) begin
            rsp_tready <= 0;
         end else begin
            if (n % 64 == 0) mode = $urandom_range(0, 2);
            case (mode)
               0: rsp_tready <= 1;
               1: rsp_tready <= ($urandom_range(0, 9) < 7);
               default: rsp_tready <= n[2] | n[4];
            endcase
         end
      end
   end

   always @(posedge clock) begin
      box_hit_type a;
      if (!reset && rsp_tvalid && rsp_tready) begin
         a.hit      = rsp_tuser;
         a.distance = rsp_tdata[30:0];
         a.pt[0]    = rsp_tdata[62:31];
         a.pt[1]    = rsp_tdata[94:63];
         a.pt[2]    = rsp_tdata[126:95];
         sb.check_result(a);
      end
   end

   initial begin
      longint one;
      one = 65536;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset box: zero size at origin
      send_xyz(-one, 0, 0, one, 0, 0);
      send_xyz(0, 0, 0, 0, 0, 0);
      send_xyz(SMIN, SMAX, SMIN, SMAX, SMIN, SMAX);

      set_box(one, 2 * one, -3 * one, 2 * one, one, one / 2);
      send_xyz(-10 * one, 2 * one, -3 * one, one, 0, 0);
      send_xyz(10 * one, 2 * one, -3 * one, -one, 0, 0);
      send_xyz(one, 2 * one, -3 * one, 0, one, 0);
      send_xyz(one, 2 * one, -3 * one, 0, 0, 0);
      send_xyz(-10 * one, 2 * one, -3 * one, -one, 0, 0);
      send_xyz(-10 * one, 10 * one, -3 * one, one, 0, 0);
      send_xyz(-one, 3 * one, -3 * one, one, 0, 0);
      send_xyz(-10 * one, 2 * one, -3 * one, 1, 0, 0);
      send_xyz(-10 * one, 2 * one, -3 * one, -1, 1, -1);
      send_xyz(-10 * one, 2 * one, -3 * one, SMAX, 0, 0);
      send_xyz(10 * one, 2 * one, -3 * one, SMIN, 0, 0);
      send_xyz(SMAX, SMAX, SMAX, SMIN, SMIN, SMIN);
      send_xyz(SMIN, SMIN, SMIN, SMAX, SMAX, SMAX);
      send_xyz(-5 * one, -3 * one, -8 * one, one, one, one);
      send_xyz(0, 0, 0, -one, -one, -one);
      send_xyz(-one, one, -one, SMIN, SMAX, 1);
      send_xyz(SMIN, 0, SMAX, 0, -1, 0);

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: set_box(0, 0, 0, one, one, one);
            1: set_box(SMAX, SMIN, SMAX, SMAX, SMAX, SMAX);
            2: set_box(SMIN, SMAX, SMIN, 0, 0, 0);
            3: set_box(0, 0, 0, SMAX, one, 1);
            default: set_box(longint'($signed($urandom)) >>> 6, longint'($signed($urandom)) >>> 6,
                             longint'($signed($urandom)) >>> 6, $urandom_range(0, 1 << 24),
                             $urandom_range(0, 1 << 24), $urandom_range(0, 1 << 24));
         endcase
         repeat (190) send_ray(make_ray());
      end
      req_tvalid <= 0;

      while (sb.hits_due.size() > 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (sb.errors == 0 && sb.hits_due.size() == 0)
         $display("ray_box_slab_intersect regression: pass");
      else
         $display("ray_box_slab_intersect regression: fail");
      $finish;
   end

endmodule

`default_nettype wire
